FILE: hdl/tlbf_pkg.sv
// Shared types and constants for the text line / binary frame demultiplexer.
package tlbf_pkg;

  localparam int PREFIX_BYTES  = 6;
  localparam int HEADER_BYTES  = 16;
  localparam int LEN_OFFSET    = 12;
  localparam int TRAILER_BYTES = 4;
  localparam int MAX_RES       = 6;

  localparam int LINE_LIMIT_W  = 13;
  localparam int FRAME_LIMIT_W = 17;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 2'd1;

  localparam logic [LINE_LIMIT_W-1:0]  LINE_LIMIT_RST  = 13'd256;
  localparam logic [FRAME_LIMIT_W-1:0] FRAME_LIMIT_RST = 17'd1024;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic [7:0] FRAME_PREFIX [PREFIX_BYTES] = '{
    8'h4B, 8'h49, 8'h42, 8'h4F, 8'h01, 8'h00
  };

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef enum logic [2:0] {
    KIND_LBYTE = 3'd0,
    KIND_LEND  = 3'd1,
    KIND_FBYTE = 3'd2,
    KIND_FLAST = 3'd3,
    KIND_LLONG = 3'd4,
    KIND_FOVER = 3'd5,
    KIND_FBIG  = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // One accepted byte's worth of results: cnt entries of res are valid.
  typedef struct packed {
    logic [2:0]            cnt;
    result_t [MAX_RES-1:0] res;
  } cmd_t;

endpackage

FILE: hdl/tlbf_if.sv
// Handshake interfaces for the byte input and the result output channels.
interface tlbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface tlbf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output data_byte, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input last, output ready);
endinterface

FILE: hdl/text_line_binary_frame_demux_core.sv
// Top level of the text line / binary frame demultiplexer.
// A byte accepted at edge t that yields results shows the first of them in the cycle after t when idle.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready; a byte that
//   releases a held prefix yields up to six results, drained one per cycle by the sequencer while the output is ready.
// The four-entry command queue sets how far the input runs ahead of a stalled output.
// Reset: synchronous, active low; clears line/frame state and the queue, restores limits.
module text_line_binary_frame_demux_core (
  input  logic                             clk,
  input  logic                             rst_n,
  tlbf_in_if.sink                          in_ch,
  tlbf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tlbf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tlbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Command path: front end classifies each accepted byte into a burst of results.
  logic           push;
  tlbf_pkg::cmd_t push_cmd;
  tlbf_pkg::cmd_t head;
  logic           pop;
  logic           empty;
  logic           full;

  // Front: hold the first line bytes until the prefix is decided, track CR and
  // the frame length, and push one command per byte that reports something.
  tlbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_full   (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: decouple byte intake from result delivery so either side can stall.
  tlbf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Back: advance through the head command one transaction at a time; flag the
  // last result of each byte and pop the command after it.
  tlbf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: hdl/tlbf_front.sv
// Front end: accepts bytes, tracks line/frame state and builds result commands.
module tlbf_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tlbf_in_if.sink                              in_ch,
  input  logic                                 cfg_we,
  input  logic [tlbf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tlbf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 push,
  output tlbf_pkg::cmd_t                       push_cmd
);

  logic [tlbf_pkg::LINE_LIMIT_W-1:0]  line_limit_r;
  logic [tlbf_pkg::FRAME_LIMIT_W-1:0] frame_limit_r;

  logic                                in_frame_r, in_frame_nxt;
  logic [tlbf_pkg::LINE_LIMIT_W-1:0]   line_count_r, line_count_nxt;
  logic                                pend_cr_r, pend_cr_nxt;
  logic [tlbf_pkg::FRAME_LIMIT_W-1:0]  frame_count_r, frame_count_nxt;
  logic [31:0]                         body_len_r, body_len_nxt;
  logic [7:0]                          held_r [tlbf_pkg::PREFIX_BYTES];
  logic                                held_we;

  logic                                accept;
  tlbf_pkg::cmd_t                      cmd;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & in_ch.ready;
  assign push        = accept & (cmd.cnt != 3'd0);
  assign push_cmd    = cmd;

  always_comb begin
    logic [7:0]                        b;
    logic [2:0]                        lc3;
    logic [2:0]                        n;
    logic [tlbf_pkg::LINE_LIMIT_W-1:0] lc1;
    logic                              match;
    logic                              is_cr;
    logic [17:0]                       fc1;
    logic [tlbf_pkg::FRAME_LIMIT_W-1:0] pos;
    logic [4:0]                        pos_rel;
    logic [32:0]                       total;

    b     = in_ch.byte_in;
    lc3   = line_count_r[2:0];
    n     = lc3;
    lc1   = line_count_r + 13'd1;
    is_cr = (b == tlbf_pkg::CH_CR);
    match = 1'b0;
    pos   = frame_count_r;
    pos_rel = 5'(pos - 17'(tlbf_pkg::LEN_OFFSET));
    fc1   = {1'b0, frame_count_r} + 18'd1;
    total = '0;

    in_frame_nxt    = in_frame_r;
    line_count_nxt  = line_count_r;
    pend_cr_nxt     = pend_cr_r;
    frame_count_nxt = frame_count_r;
    body_len_nxt    = body_len_r;
    held_we         = 1'b0;
    cmd             = '0;

    if (in_frame_r) begin
      frame_count_nxt = fc1[tlbf_pkg::FRAME_LIMIT_W-1:0];
      if (pos >= 17'(tlbf_pkg::LEN_OFFSET) && pos < 17'(tlbf_pkg::LEN_OFFSET + 4)) begin
        unique case (pos_rel[1:0])
          2'd0:    body_len_nxt = body_len_r | {24'd0, b};
          2'd1:    body_len_nxt = body_len_r | {16'd0, b, 8'd0};
          2'd2:    body_len_nxt = body_len_r | {8'd0, b, 16'd0};
          default: body_len_nxt = body_len_r | {b, 24'd0};
        endcase
      end
      total = 33'(tlbf_pkg::HEADER_BYTES + tlbf_pkg::TRAILER_BYTES) + {1'b0, body_len_nxt};
      cmd.cnt = 3'd1;
      if (fc1 > {1'b0, frame_limit_r}) begin
        in_frame_nxt = 1'b0;
        cmd.res[0].kind = tlbf_pkg::KIND_FOVER;
      end else if (fc1 >= 18'(tlbf_pkg::HEADER_BYTES) &&
                   total > {16'd0, frame_limit_r}) begin
        in_frame_nxt = 1'b0;
        cmd.res[0].kind = tlbf_pkg::KIND_FBIG;
      end else if (fc1 >= 18'(tlbf_pkg::HEADER_BYTES) && total == {15'd0, fc1}) begin
        in_frame_nxt = 1'b0;
        cmd.res[0].kind = tlbf_pkg::KIND_FLAST;
        cmd.res[0].data = b;
      end else begin
        cmd.res[0].kind = tlbf_pkg::KIND_FBYTE;
        cmd.res[0].data = b;
      end
    end else if (b == tlbf_pkg::CH_NL) begin
      // Newline: flush a still-held prefix (minus a trailing CR), then end the line.
      if (line_count_r < 13'(tlbf_pkg::PREFIX_BYTES)) begin
        if (lc3 != 3'd0 && held_r[lc3 - 3'd1] == tlbf_pkg::CH_CR) begin
          n = lc3 - 3'd1;
        end
        for (int i = 0; i < tlbf_pkg::MAX_RES; i++) begin
          if (3'(i) < n) begin
            cmd.res[i].kind = tlbf_pkg::KIND_LBYTE;
            cmd.res[i].data = held_r[3'(i)];
          end else if (3'(i) == n) begin
            cmd.res[i].kind = tlbf_pkg::KIND_LEND;
          end
        end
        cmd.cnt = (n != 3'd0) ? n + 3'd1 : 3'd0;
      end else begin
        cmd.cnt = 3'd1;
        cmd.res[0].kind = tlbf_pkg::KIND_LEND;
      end
      line_count_nxt = '0;
      pend_cr_nxt    = 1'b0;
    end else if (line_count_r >= line_limit_r) begin
      line_count_nxt = '0;
      pend_cr_nxt    = 1'b0;
      cmd.cnt = 3'd1;
      cmd.res[0].kind = tlbf_pkg::KIND_LLONG;
    end else begin
      held_we        = (line_count_r < 13'(tlbf_pkg::PREFIX_BYTES));
      line_count_nxt = lc1;
      if (lc1 == 13'(tlbf_pkg::PREFIX_BYTES)) begin
        match = (b == tlbf_pkg::FRAME_PREFIX[tlbf_pkg::PREFIX_BYTES-1]);
        for (int i = 0; i < tlbf_pkg::PREFIX_BYTES - 1; i++) begin
          if (held_r[i] != tlbf_pkg::FRAME_PREFIX[i]) begin
            match = 1'b0;
          end
        end
        for (int i = 0; i < tlbf_pkg::PREFIX_BYTES - 1; i++) begin
          cmd.res[i].kind = match ? tlbf_pkg::KIND_FBYTE : tlbf_pkg::KIND_LBYTE;
          cmd.res[i].data = held_r[i];
        end
        cmd.res[tlbf_pkg::PREFIX_BYTES-1].kind =
          match ? tlbf_pkg::KIND_FBYTE : tlbf_pkg::KIND_LBYTE;
        cmd.res[tlbf_pkg::PREFIX_BYTES-1].data = b;
        if (match) begin
          cmd.cnt         = 3'(tlbf_pkg::PREFIX_BYTES);
          in_frame_nxt    = 1'b1;
          line_count_nxt  = '0;
          pend_cr_nxt     = 1'b0;
          frame_count_nxt = 17'(tlbf_pkg::PREFIX_BYTES);
          body_len_nxt    = '0;
        end else begin
          cmd.cnt     = is_cr ? 3'(tlbf_pkg::PREFIX_BYTES - 1) : 3'(tlbf_pkg::PREFIX_BYTES);
          pend_cr_nxt = is_cr;
        end
      end else if (lc1 > 13'(tlbf_pkg::PREFIX_BYTES)) begin
        if (pend_cr_r) begin
          cmd.res[0].kind = tlbf_pkg::KIND_LBYTE;
          cmd.res[0].data = tlbf_pkg::CH_CR;
        end
        cmd.res[{2'd0, pend_cr_r}].kind = tlbf_pkg::KIND_LBYTE;
        cmd.res[{2'd0, pend_cr_r}].data = is_cr ? 8'h00 : b;
        cmd.cnt     = {2'd0, pend_cr_r} + {2'd0, ~is_cr};
        pend_cr_nxt = is_cr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r  <= tlbf_pkg::LINE_LIMIT_RST;
      frame_limit_r <= tlbf_pkg::FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tlbf_pkg::CFG_LINE_LIMIT:  line_limit_r  <= cfg_data[tlbf_pkg::LINE_LIMIT_W-1:0];
        tlbf_pkg::CFG_FRAME_LIMIT: frame_limit_r <= cfg_data[tlbf_pkg::FRAME_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      line_count_r  <= '0;
      pend_cr_r     <= 1'b0;
      frame_count_r <= '0;
      body_len_r    <= '0;
    end else if (accept) begin
      in_frame_r    <= in_frame_nxt;
      line_count_r  <= line_count_nxt;
      pend_cr_r     <= pend_cr_nxt;
      frame_count_r <= frame_count_nxt;
      body_len_r    <= body_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[line_count_r[2:0]] <= in_ch.byte_in;
    end
  end

endmodule

FILE: hdl/tlbf_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
module tlbf_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlbf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output tlbf_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  tlbf_pkg::cmd_t                 mem_r [tlbf_pkg::CMD_DEPTH];
  logic [tlbf_pkg::CMD_PTR_W-1:0] wr_ptr_r;
  logic [tlbf_pkg::CMD_PTR_W-1:0] rd_ptr_r;
  logic [tlbf_pkg::CMD_PTR_W:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == (tlbf_pkg::CMD_PTR_W+1)'(tlbf_pkg::CMD_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hdl/tlbf_back.sv
// Back end: steps through the head command and presents one result per transaction.
module tlbf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tlbf_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  tlbf_out_if.source     out_ch
);

  logic [2:0]       idx_r;
  logic             is_last;
  logic             take;
  tlbf_pkg::result_t cur;

  assign cur     = head.res[idx_r];
  assign is_last = (idx_r == head.cnt - 3'd1);
  assign take    = out_ch.valid & out_ch.ready;
  assign pop     = take & is_last;

  assign out_ch.valid     = ~empty;
  assign out_ch.kind      = cur.kind;
  assign out_ch.data_byte = cur.data;
  assign out_ch.last      = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

FILE: hdl/tlbf_checker.sv
// Port-level checker for the demultiplexer, bound to the top level.
module tlbf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_last))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_data_on_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tlbf_pkg::KIND_LBYTE && out_kind != tlbf_pkg::KIND_FBYTE &&
      out_kind != tlbf_pkg::KIND_FLAST |-> out_data_byte == 8'd0)
    else $error("nonzero data on a marker result");

  a_marks_are_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tlbf_pkg::KIND_LBYTE && out_kind != tlbf_pkg::KIND_FBYTE
      |-> out_last)
    else $error("marker result not last of its byte");

endmodule

bind text_line_binary_frame_demux_core tlbf_checker u_tlbf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_data_byte (out_ch.data_byte),
  .out_last      (out_ch.last)
);
